### rtl/smdc_pkg.sv
// Shared types and constants for the sliding median deviation block.
package smdc_pkg;

	localparam int DATA_W = 32;
	localparam int COST_W = 42;
	localparam int SIZE_W = 11;
	localparam int ACC_W  = 43;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(3);

	typedef logic signed [DATA_W-1:0] data_t;

	// Operation applied by every cell of the sorted chain in the same cycle.
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_REMOVE,
		OP_INSERT,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		data_t    key;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_INSERT,
		ST_SUM,
		ST_DONE
	} state_t;

endpackage

### rtl/smdc_if.sv
// Handshake channels for samples, results and the window size register.
interface smdc_sample_if import smdc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface smdc_result_if import smdc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] median;
	logic [COST_W-1:0]        cost;
	modport source (output valid, output median, output cost, input ready);
	modport sink (input valid, input median, input cost, output ready);
endinterface

interface smdc_cfg_if import smdc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/smdc_cell.sv
// One cell of the sorted window chain: holds one value, shifts with its neighbours.
module smdc_cell import smdc_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       valid,
	input  logic       first,
	input  logic       wrap,
	input  data_t      left_val,
	input  logic       left_le,
	input  data_t      right_val,
	input  data_t      head_val,
	output data_t      val,
	output logic       le
);

	data_t val_q;
	data_t val_d;

	assign val = val_q;
	// A valid cell at or below the key stays in place on insertion.
	assign le = valid && (val_q <= ctrl.key);

	// Next value from the cell's own contents and its neighbours.
	always_comb begin
		val_d = val_q;
		case (ctrl.op)
			OP_REMOVE: begin
				if (valid && (val_q >= ctrl.key)) begin
					val_d = right_val;
				end
			end
			OP_INSERT: begin
				if (!le) begin
					val_d = (first || left_le) ? ctrl.key : left_val;
				end
			end
			OP_ROTATE: begin
				val_d = wrap ? head_val : right_val;
			end
			default: begin
				val_d = val_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

endmodule

### rtl/sliding_median_deviation_cost_top.sv
// Top level of the sliding window median and absolute deviation sum.
//
// Samples arrive on the samples channel, results leave on the results channel,
// and the window size is to be written through the cfg channel while the block
// is idle; the block itself does not enforce this. A write of the window size
// empties the window; a size of zero acts as one and a size above WINDOW_MAX
// acts as WINDOW_MAX. The window is kept sorted in a chain of cells, one value
// each. A sample that finds the window full first removes the leaving sample,
// then is inserted. Once the window is full, the chain is rotated through its
// first k cells, k being the window size, while the head cell feeds the
// deviation accumulator; the result then goes into the output register once
// that register is free.
// The result waits in the output register while the receiver stalls; the next
// sample is taken meanwhile, and only its result waits for the register.
// Reset empties the window and sets the window size to 3.
module sliding_median_deviation_cost_top import smdc_pkg::*; #(
	parameter int WINDOW_MAX = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	smdc_sample_if.sink          samples,
	smdc_result_if.source        results,
	smdc_cfg_if.sink             cfg
);

	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW = $clog2(WINDOW_MAX + 1);

	state_t             state_q;
	state_t             state_d;
	logic [SIZE_W-1:0]  size_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      t_q;
	logic [AW-1:0]      ptr_q;
	data_t              key_q;
	data_t              old_q;
	data_t              med_q;
	logic signed [ACC_W-1:0] acc_q;
	logic               res_v_q;
	data_t              res_med_q;
	logic [COST_W-1:0]  res_cost_q;

	logic [CW-1:0]      k;
	logic [CW-1:0]      k_m1;
	logic [CW:0]        mi;
	logic               take;
	logic               load;
	cell_ctrl_t         ctrl;

	data_t              data_mem [WINDOW_MAX];
	data_t              vals [WINDOW_MAX];
	logic               les [WINDOW_MAX];

	// Effective window size.
	always_comb begin
		if (size_q == '0) begin
			k = CW'(1);
		end else if (32'(size_q) > 32'(WINDOW_MAX)) begin
			k = CW'(WINDOW_MAX);
		end else begin
			k = CW'(size_q);
		end
	end
	assign k_m1 = k - CW'(1);
	assign mi = ({1'b0, k} + (CW+1)'(1)) >> 1;

	assign cfg.ready = 1'b1;
	assign samples.ready = (state_q == ST_IDLE);
	assign take = samples.valid && samples.ready;
	assign load = (state_q == ST_DONE) && (!res_v_q || results.ready);

	// Arrival order store; the read returns the sample that leaves.
	always_ff @(posedge clk) begin
		if (take) begin
			old_q <= data_mem[ptr_q];
			data_mem[ptr_q] <= samples.sample;
		end
	end

	// Sequencer: next state and cell operation.
	always_comb begin
		state_d = state_q;
		ctrl.op = OP_HOLD;
		ctrl.key = key_q;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					state_d = (cnt_q == k) ? ST_REMOVE : ST_INSERT;
				end
			end
			ST_REMOVE: begin
				ctrl.op = OP_REMOVE;
				ctrl.key = old_q;
				state_d = ST_INSERT;
			end
			ST_INSERT: begin
				ctrl.op = OP_INSERT;
				state_d = ((cnt_q + CW'(1)) == k) ? ST_SUM : ST_IDLE;
			end
			ST_SUM: begin
				ctrl.op = OP_ROTATE;
				if (t_q == k_m1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Window bookkeeping and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			cnt_q <= '0;
			ptr_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			size_q <= cfg.data;
			cnt_q <= '0;
			ptr_q <= '0;
		end else begin
			if (take) begin
				ptr_q <= ({1'b0, ptr_q} >= (AW+1)'(k_m1)) ? '0 : ptr_q + AW'(1);
			end
			if (state_q == ST_REMOVE) begin
				cnt_q <= cnt_q - CW'(1);
			end else if (state_q == ST_INSERT) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_q <= samples.sample;
		end
	end

	// Deviation accumulator fed by the head cell during the rotation.
	always_ff @(posedge clk) begin
		if (state_q == ST_INSERT) begin
			t_q <= '0;
			acc_q <= '0;
		end else if (state_q == ST_SUM) begin
			t_q <= t_q + CW'(1);
			if ({1'b0, t_q} < mi) begin
				acc_q <= acc_q - ACC_W'(vals[0]);
			end else begin
				acc_q <= acc_q + ACC_W'(vals[0]);
			end
			if ({1'b0, t_q} == (mi - (CW+1)'(1))) begin
				med_q <= vals[0];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (load) begin
			res_v_q <= 1'b1;
		end else if (results.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_med_q <= med_q;
			res_cost_q <= COST_W'(acc_q + (k[0] ? ACC_W'(med_q) : ACC_W'(0)));
		end
	end

	assign results.valid = res_v_q;
	assign results.median = res_med_q;
	assign results.cost = res_cost_q;

	// Chain of sorted window cells.
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		data_t lv;
		logic  ll;
		data_t rv;
		if (i == 0) begin : g_first
			assign lv = '0;
			assign ll = 1'b0;
		end else begin : g_mid
			assign lv = vals[i-1];
			assign ll = les[i-1];
		end
		if (i == WINDOW_MAX - 1) begin : g_last
			assign rv = vals[i];
		end else begin : g_inner
			assign rv = vals[i+1];
		end
		smdc_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.valid     (CW'(i) < cnt_q),
			.first     (i == 0),
			.wrap      (CW'(i) == k_m1),
			.left_val  (lv),
			.left_le   (ll),
			.right_val (rv),
			.head_val  (vals[0]),
			.val       (vals[i]),
			.le        (les[i])
		);
	end

endmodule

### tb/sv/sliding_median_deviation_cost_top_tb.sv
// Self-checking testbench for the sliding window median and deviation sum block.
`timescale 1ns / 100ps

module sliding_median_deviation_cost_top_tb;
	import smdc_pkg::*;

	localparam int WMAX = 1024;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	smdc_sample_if samples_if ();
	smdc_result_if results_if ();
	smdc_cfg_if cfg_if ();

	sliding_median_deviation_cost_top #(.WINDOW_MAX(WMAX)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if.sink),
		.results(results_if.source),
		.cfg(cfg_if.sink)
	);

	typedef struct {
		data_t median;
		logic [COST_W-1:0] cost;
	} window_result_t;

	// Predictor state: arrival ring, sorted copy, pointer, fill level, size.
	data_t arrival_ring [WMAX];
	data_t sorted_vals [WMAX];
	int unsigned ring_slot;
	int unsigned held_count;
	logic [SIZE_W-1:0] size_reg;

	data_t pending_samples [$];
	window_result_t expected_results [$];
	int fail_count = 0;
	longint cycle_count = 0;
	bit hold_results = 1'b0;
	int hold_cycles = 0;
	bit in_taken = 1'b0;
	bit out_taken = 1'b0;

	// Clock.
	always #5 clk = ~clk;

	// Window length actually used for a register value.
	function automatic int unsigned active_size(logic [SIZE_W-1:0] v);
		if (v == 0) begin
			return 1;
		end
		if (v > WMAX) begin
			return WMAX;
		end
		return int'(v);
	endfunction

	// Inserts a value in the first n sorted entries.
	task automatic sorted_put(int unsigned n, data_t v);
		int unsigned pos;
		pos = 0;
		while (pos < n && sorted_vals[pos] <= v) pos++;
		for (int unsigned j = n; j > pos; j--) sorted_vals[j] = sorted_vals[j-1];
		sorted_vals[pos] = v;
	endtask

	// Takes in one sample and queues the result it causes, if any.
	task automatic predict_window(data_t s);
		int unsigned k;
		int unsigned p;
		int unsigned pos;
		data_t leaving;
		data_t med;
		longint diff;
		logic [COST_W-1:0] acc;
		window_result_t r;
		k = active_size(size_reg);
		p = ring_slot % k;
		if (held_count < k) begin
			arrival_ring[p] = s;
			sorted_put(held_count, s);
			held_count++;
		end else begin
			leaving = arrival_ring[p];
			arrival_ring[p] = s;
			pos = 0;
			while (pos < k && sorted_vals[pos] != leaving) pos++;
			for (int unsigned j = pos; j + 1 < k; j++) sorted_vals[j] = sorted_vals[j+1];
			sorted_put(k - 1, s);
		end
		ring_slot = (p + 1) % k;
		if (held_count >= k) begin
			med = sorted_vals[(k + 1) / 2 - 1];
			acc = '0;
			for (int unsigned j = 0; j < k; j++) begin
				diff = longint'(sorted_vals[j]) - longint'(med);
				acc += COST_W'(diff < 0 ? -diff : diff);
			end
			r.median = med;
			r.cost = acc;
			expected_results.push_back(r);
		end
	endtask

	// Random sample, biased towards extremes and small values for duplicates.
	function automatic data_t random_sample();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff - $urandom_range(0, 3);
			1: return 32'sh80000000 + $urandom_range(0, 3);
			2: return data_t'($urandom_range(0, 8)) - 4;
			default: return data_t'($urandom);
		endcase
	endfunction

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sliding_median_deviation_cost_top_tb NOT OK");
			$finish;
		end
	end

	// Handshakes seen at the rising edge, for the processes that act at the falling edge.
	always @(posedge clk) begin
		in_taken <= arst_n && samples_if.valid && samples_if.ready;
		out_taken <= arst_n && results_if.valid && results_if.ready;
	end

	// Sample driver: offers queued items with random gaps.
	int send_gap = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			samples_if.valid <= 1'b0;
		end else if (in_taken) begin
			void'(pending_samples.pop_front());
			send_gap = $urandom_range(0, 7);
			if (send_gap == 0 && pending_samples.size() > 0) begin
				samples_if.sample <= pending_samples[0];
			end else begin
				samples_if.valid <= 1'b0;
			end
		end else if (!samples_if.valid) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_samples.size() > 0) begin
				samples_if.valid <= 1'b1;
				samples_if.sample <= pending_samples[0];
			end
		end
	end

	// Long receiver hold-off, counted in cycles.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// Result receiver: random ready with stalls.
	int recv_gap = 0;
	always @(negedge clk) begin
		if (!arst_n || hold_cycles > 0) begin
			results_if.ready <= 1'b0;
		end else if (out_taken) begin
			recv_gap = $urandom_range(0, 7);
			results_if.ready <= (recv_gap == 0);
		end else if (!results_if.ready) begin
			if (recv_gap > 0) begin
				recv_gap--;
			end else begin
				results_if.ready <= 1'b1;
			end
		end
	end

	// Monitor: predicts on accepted samples and checks accepted results.
	always @(posedge clk) begin
		if (arst_n) begin
			if (samples_if.valid && samples_if.ready) begin
				predict_window(samples_if.sample);
			end
			if (results_if.valid && results_if.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result median %0d cost %0d", $time,
						results_if.median, results_if.cost);
					fail_count++;
				end else begin
					if (results_if.median !== expected_results[0].median) begin
						$display("%0t: median expected %0d actual %0d", $time,
							expected_results[0].median, results_if.median);
						fail_count++;
					end
					if (results_if.cost !== expected_results[0].cost) begin
						$display("%0t: cost expected %0d actual %0d", $time,
							expected_results[0].cost, results_if.cost);
						fail_count++;
					end
					void'(expected_results.pop_front());
				end
			end
		end
	end

	// Waits until every queued sample is taken and every result has come.
	task automatic drain_block();
		while (pending_samples.size() > 0 || samples_if.valid ||
			expected_results.size() > 0) @(posedge clk);
		repeat (2 * WMAX + 20) @(posedge clk);
	endtask

	// Writes the window size while idle; the predictor empties its window.
	task automatic write_size(logic [SIZE_W-1:0] v);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= v;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		size_reg = v;
		held_count = 0;
		ring_slot = 0;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic queue_random(int n);
		repeat (n) pending_samples.push_back(random_sample());
	endtask

	initial begin
		int phase_sizes [$];
		samples_if.valid = 1'b0;
		samples_if.sample = '0;
		results_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		size_reg = SIZE_RESET;
		held_count = 0;
		ring_slot = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset size of three with extremes, duplicates and zero.
		pending_samples.push_back(32'sh7fffffff);
		pending_samples.push_back(32'sh80000000);
		pending_samples.push_back(32'sh7fffffff);
		pending_samples.push_back(32'sh80000000);
		pending_samples.push_back(0);
		pending_samples.push_back(0);
		pending_samples.push_back(0);
		pending_samples.push_back(-1);
		pending_samples.push_back(1);
		pending_samples.push_back(-1);
		drain_block();

		// Size zero acts as one, then a size of two.
		write_size(SIZE_W'(0));
		pending_samples.push_back(32'sh80000000);
		pending_samples.push_back(5);
		pending_samples.push_back(32'sh7fffffff);
		drain_block();
		write_size(SIZE_W'(2));
		pending_samples.push_back(32'sh80000000);
		pending_samples.push_back(32'sh7fffffff);
		pending_samples.push_back(-7);
		pending_samples.push_back(-7);
		drain_block();

		// Receiver holds off while the sender keeps offering items.
		write_size(SIZE_W'(4));
		hold_cycles = 300;
		queue_random(60);
		drain_block();

		// Random phases over several sizes; one size above the maximum, which acts as the maximum.
		phase_sizes = '{1, 3, 5, 8, 16, 2, 7, 31, 1, 6};
		foreach (phase_sizes[i]) begin
			write_size(SIZE_W'(phase_sizes[i]));
			queue_random(phase_sizes[i] + 12);
			drain_block();
		end
		write_size(11'd2047);
		queue_random(WMAX + 30);
		drain_block();
		write_size(SIZE_W'(3));
		queue_random(40);
		drain_block();

		if (fail_count == 0) begin
			$display("sliding_median_deviation_cost_top_tb OK");
		end else begin
			$display("sliding_median_deviation_cost_top_tb NOT OK");
		end
		$finish;
	end

endmodule

### sliding_median_deviation_cost_top.f
rtl/smdc_pkg.sv
rtl/smdc_if.sv
rtl/smdc_cell.sv
rtl/sliding_median_deviation_cost_top.sv
tb/sv/sliding_median_deviation_cost_top_tb.sv
